FILE: hdl/mjd_pkg.sv
package mjd_pkg;

    localparam int JOB_SLOTS_DEF  = 64;
    localparam int CORE_COUNT_DEF = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'd1;

    localparam logic [2:0] POL_FCFS = 3'd0;
    localparam logic [2:0] POL_SJF  = 3'd1;
    localparam logic [2:0] POL_PSJF = 3'd2;
    localparam logic [2:0] POL_PRI  = 3'd3;
    localparam logic [2:0] POL_PPRI = 3'd4;
    localparam logic [2:0] POL_RR   = 3'd5;

    localparam logic [1:0] KIND_ARRIVE = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_EXPIRE = 2'd2;
    localparam logic [1:0] KIND_RSVD   = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] job_id;
        logic [31:0] now;
        logic [15:0] run_length;
        logic [7:0]  job_priority;
        logic [2:0]  core_index;
    } t_in;

    typedef struct packed {
        logic        assigned;
        logic [2:0]  target_core;
        logic [15:0] core_job;
        logic [47:0] wait_sum;
        logic [47:0] turnaround_sum;
        logic [47:0] response_sum;
        logic [15:0] finished_count;
    } t_out;

    // one job table record
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] fa;    // first arrival
        logic [31:0] qt;    // queue time
        logic [7:0]  urg;
        logic [15:0] rem;
        logic [15:0] len;
        logic        seen;  // has run at least once
        logic [31:0] fr;    // first run
        logic [31:0] ls;    // last start
    } t_entry;

    typedef struct packed {
        logic [15:0] rem;
        logic [7:0]  urg;
        logic [31:0] qt;
    } t_key;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_CHG, S_CHG_WR, S_FREE, S_NEW, S_VIC_RD, S_VIC_CMP,
        S_PRE, S_REL_RD, S_REL_WR, S_STAT, S_SCAN, S_SCAN_END, S_DISP_RD,
        S_DISP_WR, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CHG_RD, OP_CHG_SKIP, OP_CHG_WR, OP_FREE, OP_NEW,
        OP_VIC_RD, OP_VIC_CMP, OP_PRE, OP_REL_RD, OP_REL_WR, OP_STAT, OP_SCAN,
        OP_SCAN_END, OP_DISP_RD, OP_DISP_WR
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic is_arrive;
        logic is_finish;
        logic rel_ok;
        logic psjf;
        logic preempt;
        logic chg_busy;
        logic chg_last;
        logic free_hit;
        logic free_last;
        logic idle_hit;
        logic vic_last;
        logic in_active;
        logic scan_last;
        logic found;
    } t_stat;

    function automatic t_key key_of(t_entry e);
        t_key k;
        k.rem = e.rem;
        k.urg = e.urg;
        k.qt  = e.qt;
        return k;
    endfunction

    // a ahead of b; a_lower breaks the final tie by table slot
    function automatic logic rank_before(logic [2:0] pol, t_key a, t_key b,
                                         logic a_lower);
        logic r;
        if ((pol == POL_SJF || pol == POL_PSJF) && a.rem != b.rem) begin
            r = a.rem < b.rem;
        end else if ((pol == POL_PRI || pol == POL_PPRI) && a.urg != b.urg) begin
            r = a.urg < b.urg;
        end else if (a.qt != b.qt) begin
            r = a.qt < b.qt;
        end else begin
            r = a_lower;
        end
        return r;
    endfunction

endpackage

FILE: hdl/mjd_ctrl.sv
module mjd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  mjd_pkg::t_stat i_stat,
    output mjd_pkg::t_cmd  o_cmd,
    output logic          o_busy,
    output logic          o_done
);
    import mjd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_start) n_state = S_DECODE;
            S_DECODE: begin
                if (i_stat.is_arrive)   n_state = S_FREE;
                else if (i_stat.rel_ok) n_state = S_REL_RD;
                else                    n_state = S_DONE;
            end
            S_CHG: begin
                if (i_stat.chg_busy)      n_state = S_CHG_WR;
                else if (i_stat.chg_last) n_state = S_NEW;
            end
            S_CHG_WR:   n_state = i_stat.chg_last ? S_NEW : S_CHG;
            S_FREE: begin
                if (i_stat.free_hit)       n_state = i_stat.psjf ? S_CHG : S_NEW;
                else if (i_stat.free_last) n_state = S_DONE;
            end
            S_NEW: begin
                if (i_stat.idle_hit)     n_state = S_DONE;
                else if (i_stat.preempt) n_state = S_VIC_RD;
                else                     n_state = S_DONE;
            end
            S_VIC_RD:   n_state = S_VIC_CMP;
            S_VIC_CMP:  n_state = i_stat.vic_last ? S_PRE : S_VIC_RD;
            S_PRE:      n_state = S_DONE;
            S_REL_RD:   n_state = S_REL_WR;
            S_REL_WR: begin
                if (i_stat.is_finish)      n_state = S_STAT;
                else if (i_stat.in_active) n_state = S_SCAN;
                else                       n_state = S_DONE;
            end
            S_STAT:     n_state = i_stat.in_active ? S_SCAN : S_DONE;
            S_SCAN:     if (i_stat.scan_last) n_state = S_SCAN_END;
            S_SCAN_END: n_state = S_DISP_RD;
            S_DISP_RD:  n_state = i_stat.found ? S_DISP_WR : S_DONE;
            S_DISP_WR:  n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE:     o_cmd.op = i_start ? OP_LOAD : OP_NONE;
            S_CHG:      o_cmd.op = i_stat.chg_busy ? OP_CHG_RD : OP_CHG_SKIP;
            S_CHG_WR:   o_cmd.op = OP_CHG_WR;
            S_FREE:     o_cmd.op = OP_FREE;
            S_NEW:      o_cmd.op = OP_NEW;
            S_VIC_RD:   o_cmd.op = OP_VIC_RD;
            S_VIC_CMP:  o_cmd.op = OP_VIC_CMP;
            S_PRE:      o_cmd.op = OP_PRE;
            S_REL_RD:   o_cmd.op = OP_REL_RD;
            S_REL_WR:   o_cmd.op = OP_REL_WR;
            S_STAT:     o_cmd.op = OP_STAT;
            S_SCAN:     o_cmd.op = OP_SCAN;
            S_SCAN_END: o_cmd.op = OP_SCAN_END;
            S_DISP_RD:  o_cmd.op = OP_DISP_RD;
            S_DISP_WR:  o_cmd.op = OP_DISP_WR;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

FILE: hdl/mjd_datapath.sv
module mjd_datapath #(
    parameter int JOB_SLOTS  = mjd_pkg::JOB_SLOTS_DEF,
    parameter int CORE_COUNT = mjd_pkg::CORE_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mjd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mjd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  mjd_pkg::t_in                     i_in,
    input  mjd_pkg::t_cmd                    i_cmd,
    output mjd_pkg::t_stat                   o_stat,
    output mjd_pkg::t_out                    o_out
);
    import mjd_pkg::*;

    localparam int SW = $clog2(JOB_SLOTS);
    localparam int CW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;

    // config
    logic [2:0] r_policy;
    logic [3:0] r_active;

    // control state
    logic [JOB_SLOTS-1:0]  r_valid;
    logic [JOB_SLOTS-1:0]  r_run;
    logic [CORE_COUNT-1:0] r_busy;
    logic [SW-1:0]         r_cslot [CORE_COUNT];
    logic [CW:0]           r_cc;
    logic [SW:0]           r_sc;
    logic                  r_pv;
    logic                  r_found;
    logic                  r_assigned;
    logic [2:0]            r_target;
    logic [15:0]           r_next;
    logic [47:0]           r_wait_sum;
    logic [47:0]           r_turn_sum;
    logic [47:0]           r_resp_sum;
    logic [15:0]           r_count;

    // payload
    t_in           r_in;
    logic [SW-1:0] r_slot;
    logic [CW-1:0] r_vic;
    t_key          r_vkey;
    logic [SW-1:0] r_vslot;
    t_key          r_bkey;
    logic [SW-1:0] r_bslot;
    logic [SW-1:0] r_pslot;
    logic [31:0]   r_turn;
    logic [31:0]   r_resp;
    logic [31:0]   r_wait;

    t_entry r_mem [JOB_SLOTS];
    t_entry r_rd;

    logic [SW-1:0] rd_addr;
    logic          mem_we;
    logic [SW-1:0] wr_addr;
    t_entry        wr_data;

    logic [5:0]    act6;
    logic [5:0]    nc6;
    logic [CW+2:0] rcore_ext;
    logic [CW-1:0] rcore;
    logic          core_ok;
    logic [CW-1:0] cc_idx;
    logic [SW-1:0] sc_idx;
    logic [SW-1:0] cur_cslot;
    logic          idle_hit;
    logic [CW-1:0] idle_idx;
    logic [CW+2:0] idle_ext;
    logic [CW+2:0] vic_ext;
    t_entry        new_e;
    t_key          new_key;
    logic          vtake;
    logic          pre_win;
    logic          stake;
    logic          elig;
    logic [31:0]   turn_c;
    logic [31:0]   wait_c;
    t_entry        rel_e;
    t_entry        disp_e;

    function automatic t_entry charge(t_entry e, logic [31:0] now);
        logic [31:0] el;
        t_entry r;
        el = now - e.ls;
        r  = e;
        if (el >= {16'd0, e.rem}) r.rem = 16'd0;
        else                      r.rem = e.rem - el[15:0];
        r.ls = now;
        return r;
    endfunction

    function automatic logic [47:0] sat_add(logic [47:0] a, logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    assign act6      = {2'b00, r_active};
    assign nc6       = (act6 == 6'd0) ? 6'd1 :
                       ((act6 > 6'(CORE_COUNT)) ? 6'(CORE_COUNT) : act6);
    assign rcore_ext = {{CW{1'b0}}, r_in.core_index};
    assign rcore     = rcore_ext[CW-1:0];
    assign core_ok   = rcore_ext < (CW+3)'(CORE_COUNT);
    assign cc_idx    = r_cc[CW-1:0];
    assign sc_idx    = r_sc[SW-1:0];
    assign cur_cslot = r_cslot[cc_idx];

    // lowest idle core among the active ones
    always_comb begin
        idle_hit = 1'b0;
        idle_idx = '0;
        for (int c = CORE_COUNT - 1; c >= 0; c--) begin
            if (!r_busy[c] && (6'(c) < nc6)) begin
                idle_hit = 1'b1;
                idle_idx = CW'(c);
            end
        end
    end

    assign idle_ext = {3'b000, idle_idx};
    assign vic_ext  = {3'b000, r_vic};

    always_comb begin
        new_e.id   = r_in.job_id;
        new_e.fa   = r_in.now;
        new_e.qt   = r_in.now;
        new_e.urg  = r_in.job_priority;
        new_e.rem  = r_in.run_length;
        new_e.len  = r_in.run_length;
        new_e.seen = 1'b0;
        new_e.fr   = 32'd0;
        new_e.ls   = r_in.now;
    end

    assign new_key = key_of(new_e);
    assign vtake   = (r_cc == '0) ||
                     rank_before(r_policy, r_vkey, key_of(r_rd), r_vslot < cur_cslot);
    assign pre_win = rank_before(r_policy, new_key, r_vkey, r_slot < r_vslot);
    assign stake   = r_pv &&
                     (!r_found || rank_before(r_policy, key_of(r_rd), r_bkey,
                                              r_pslot < r_bslot));
    assign elig    = r_valid[sc_idx] && !r_run[sc_idx];
    assign turn_c  = r_in.now - r_rd.fa;
    assign wait_c  = (turn_c >= {16'd0, r_rd.len}) ? (turn_c - {16'd0, r_rd.len}) : 32'd0;

    always_comb begin
        rel_e = (r_policy == POL_PSJF) ? charge(r_rd, r_in.now) : r_rd;
        if (r_policy == POL_RR) rel_e.qt = r_in.now;
    end

    always_comb begin
        disp_e    = r_rd;
        disp_e.ls = r_in.now;
        if (!r_rd.seen) begin
            disp_e.seen = 1'b1;
            disp_e.fr   = r_in.now;
        end
    end

    // memory port select
    always_comb begin
        rd_addr = r_slot;
        mem_we  = 1'b0;
        wr_addr = r_slot;
        wr_data = new_e;
        case (i_cmd.op)
            OP_CHG_RD:  rd_addr = cur_cslot;
            OP_CHG_WR: begin
                mem_we  = 1'b1;
                wr_addr = cur_cslot;
                wr_data = charge(r_rd, r_in.now);
            end
            OP_NEW: begin
                mem_we       = 1'b1;
                wr_data.seen = idle_hit;
                wr_data.fr   = idle_hit ? r_in.now : 32'd0;
            end
            OP_VIC_RD:  rd_addr = cur_cslot;
            OP_PRE: begin
                mem_we       = pre_win;
                wr_data.seen = 1'b1;
                wr_data.fr   = r_in.now;
            end
            OP_REL_RD:  rd_addr = r_cslot[rcore];
            OP_REL_WR: begin
                mem_we  = (r_in.kind != KIND_FINISH);
                wr_data = rel_e;
            end
            OP_SCAN:    rd_addr = sc_idx;
            OP_DISP_RD: rd_addr = r_bslot;
            OP_DISP_WR: begin
                mem_we  = 1'b1;
                wr_addr = r_bslot;
                wr_data = disp_e;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= POL_FCFS;
            r_active   <= 4'd1;
            r_valid    <= '0;
            r_run      <= '0;
            r_busy     <= '0;
            for (int c = 0; c < CORE_COUNT; c++) r_cslot[c] <= '0;
            r_cc       <= '0;
            r_sc       <= '0;
            r_pv       <= 1'b0;
            r_found    <= 1'b0;
            r_assigned <= 1'b0;
            r_target   <= '0;
            r_next     <= '0;
            r_wait_sum <= '0;
            r_turn_sum <= '0;
            r_resp_sum <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POLICY: r_policy <= i_cfg_data[2:0];
                    REG_ACTIVE: r_active <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_assigned <= 1'b0;
                    r_target   <= '0;
                    r_next     <= '0;
                    r_cc       <= '0;
                    r_sc       <= '0;
                    r_pv       <= 1'b0;
                    r_found    <= 1'b0;
                end
                OP_CHG_SKIP, OP_CHG_WR, OP_VIC_CMP: r_cc <= r_cc + 1'b1;
                OP_FREE: if (r_valid[sc_idx]) r_sc <= r_sc + 1'b1;
                OP_NEW: begin
                    r_valid[r_slot] <= 1'b1;
                    r_cc            <= '0;
                    if (idle_hit) begin
                        r_busy[idle_idx]  <= 1'b1;
                        r_cslot[idle_idx] <= r_slot;
                        r_run[r_slot]     <= 1'b1;
                        r_assigned        <= 1'b1;
                        r_target          <= idle_ext[2:0];
                    end
                end
                OP_PRE: begin
                    if (pre_win) begin
                        r_run[r_vslot] <= 1'b0;
                        r_run[r_slot]  <= 1'b1;
                        r_cslot[r_vic] <= r_slot;
                        r_assigned     <= 1'b1;
                        r_target       <= vic_ext[2:0];
                    end
                end
                OP_REL_RD: begin
                    r_busy[rcore]          <= 1'b0;
                    r_run[r_cslot[rcore]]  <= 1'b0;
                end
                OP_REL_WR: if (r_in.kind == KIND_FINISH) r_valid[r_slot] <= 1'b0;
                OP_STAT: begin
                    r_turn_sum <= sat_add(r_turn_sum, r_turn);
                    r_wait_sum <= sat_add(r_wait_sum, r_wait);
                    r_resp_sum <= sat_add(r_resp_sum, r_resp);
                    if (r_count != 16'hFFFF) r_count <= r_count + 16'd1;
                end
                OP_SCAN: begin
                    r_sc <= r_sc + 1'b1;
                    r_pv <= elig;
                    if (stake) r_found <= 1'b1;
                end
                OP_SCAN_END: begin
                    r_pv <= 1'b0;
                    if (stake) r_found <= 1'b1;
                end
                OP_DISP_WR: begin
                    r_busy[rcore]  <= 1'b1;
                    r_cslot[rcore] <= r_bslot;
                    r_run[r_bslot] <= 1'b1;
                    r_assigned     <= 1'b1;
                    r_next         <= r_rd.id;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD:   r_in   <= i_in;
            OP_FREE:   r_slot <= sc_idx;
            OP_VIC_CMP: begin
                if (vtake) begin
                    r_vic   <= cc_idx;
                    r_vkey  <= key_of(r_rd);
                    r_vslot <= cur_cslot;
                end
            end
            OP_REL_RD: r_slot <= r_cslot[rcore];
            OP_REL_WR: begin
                r_turn <= turn_c;
                r_wait <= wait_c;
                r_resp <= r_rd.fr - r_rd.fa;
            end
            OP_SCAN, OP_SCAN_END: begin
                r_pslot <= sc_idx;
                if (stake) begin
                    r_bkey  <= key_of(r_rd);
                    r_bslot <= r_pslot;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.is_arrive = (r_in.kind == KIND_ARRIVE);
        o_stat.is_finish = (r_in.kind == KIND_FINISH);
        o_stat.rel_ok    = ((r_in.kind == KIND_FINISH) || (r_in.kind == KIND_EXPIRE)) &&
                           core_ok && r_busy[rcore];
        o_stat.psjf      = (r_policy == POL_PSJF);
        o_stat.preempt   = (r_policy == POL_PSJF) || (r_policy == POL_PPRI);
        o_stat.chg_busy  = r_busy[cc_idx];
        o_stat.chg_last  = (r_cc == (CW+1)'(CORE_COUNT - 1));
        o_stat.free_hit  = !r_valid[sc_idx];
        o_stat.free_last = (r_sc == (SW+1)'(JOB_SLOTS - 1));
        o_stat.idle_hit  = idle_hit;
        o_stat.vic_last  = ((6'(r_cc) + 6'd1) == nc6);
        o_stat.in_active = ({3'b000, r_in.core_index} < nc6);
        o_stat.scan_last = (r_sc == (SW+1)'(JOB_SLOTS - 1));
        o_stat.found     = r_found;
    end

    always_comb begin
        o_out.assigned       = r_assigned;
        o_out.target_core    = r_target;
        o_out.core_job       = r_next;
        o_out.wait_sum       = r_wait_sum;
        o_out.turnaround_sum = r_turn_sum;
        o_out.response_sum   = r_resp_sum;
        o_out.finished_count = r_count;
    end

endmodule

FILE: hdl/multicore_job_dispatcher.sv
// Multicore job dispatcher. Pulse i_start while o_busy is low to hand over one
// event (arrival, finish or quantum expiry); the block answers with exactly one
// result, shown on o_out for the single cycle in which o_done is high. There is
// no back-pressure on the result side: the receiver must take the transfer in
// that cycle. One event is in flight at a time. An event that is neither an
// arrival nor a release of a busy core goes straight to its result. A finish
// or an expiry on a busy core frees the core and, if the core is active, runs
// a linear scan of the job table through its single read port, one slot per
// cycle. An arrival runs a free-slot search, then per-core charging under
// preemptive SJF and a victim search under the preemptive modes, each charge
// and each victim compare costing a table read.
// Policy and active core count are written through i_cfg_*; write them only
// while o_busy is low.
module multicore_job_dispatcher #(
    parameter int JOB_SLOTS  = mjd_pkg::JOB_SLOTS_DEF,
    parameter int CORE_COUNT = mjd_pkg::CORE_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mjd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mjd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_start,
    input  mjd_pkg::t_in                   i_in,
    output logic                           o_busy,
    output logic                           o_done,
    output mjd_pkg::t_out                  o_out
);
    import mjd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: walks each event through its table reads and writes
    mjd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    // job table, core map, ranking compares and running totals
    mjd_datapath #(
        .JOB_SLOTS  (JOB_SLOTS),
        .CORE_COUNT (CORE_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out      (o_out)
    );

endmodule

FILE: hdl/mjd_checker.sv
module mjd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input logic          o_done,
    input mjd_pkg::t_out o_out
);

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("no busy after accept");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_out.assigned) |-> (o_out.target_core == 3'd0 &&
                                         o_out.core_job == 16'd0))
        else $error("fields set without assignment");

    // totals move only while an event is in flight
    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && !i_start) |=> ($stable(o_out.finished_count) &&
                                   $stable(o_out.turnaround_sum)))
        else $error("totals changed while idle");

endmodule

bind multicore_job_dispatcher mjd_checker u_mjd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_out   (o_out)
);

FILE: tb/mjd_checker.sv
module mjd_tb_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [3:0]    i_cfg_data,
    input  logic          i_start,
    input  logic          i_busy,
    input  mjd_pkg::t_in  i_in,
    input  logic          i_done,
    input  mjd_pkg::t_out i_out,
    output int            o_errors,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mjd_pkg::*;

    localparam int SLOTS = 64;
    localparam int CORES = 8;
    localparam logic [47:0] SUM_SAT = 48'hFFFF_FFFF_FFFF;

    logic [2:0]  pol;
    logic [3:0]  ncfg;
    logic        jv   [SLOTS];
    logic [15:0] jid  [SLOTS];
    logic [31:0] jarr [SLOTS];
    logic [31:0] jqt  [SLOTS];
    logic [7:0]  jurg [SLOTS];
    logic [15:0] jrem [SLOTS];
    logic [15:0] jlen [SLOTS];
    logic        jseen[SLOTS];
    logic [31:0] jfr  [SLOTS];
    logic [31:0] jls  [SLOTS];
    logic        cbusy[CORES];
    int          cslot[CORES];
    logic [47:0] wsum, tsum, rsum;
    logic [15:0] ndone;
    t_out        sched_q[$];

    function automatic logic bool_ahead(int a, int b);
        if ((pol == POL_SJF || pol == POL_PSJF) && jrem[a] != jrem[b]) return jrem[a] < jrem[b];
        if ((pol == POL_PRI || pol == POL_PPRI) && jurg[a] != jurg[b]) return jurg[a] < jurg[b];
        if (jqt[a] != jqt[b]) return jqt[a] < jqt[b];
        return a < b;
    endfunction

    function automatic logic on_core(int s);
        for (int c = 0; c < CORES; c++) if (cbusy[c] && cslot[c] == s) return 1;
        return 0;
    endfunction

    function automatic void charge(int s, logic [31:0] t);
        logic [31:0] el;
        el = t - jls[s];
        jrem[s] = (el >= jrem[s]) ? 16'd0 : jrem[s] - el[15:0];
        jls[s] = t;
    endfunction

    function automatic void run_on(int c, int s, logic [31:0] t);
        cbusy[c] = 1;
        cslot[c] = s;
        jls[s] = t;
        if (!jseen[s]) begin
            jseen[s] = 1;
            jfr[s] = t;
        end
    endfunction

    function automatic logic [47:0] sat(logic [47:0] a, logic [31:0] b);
        logic [48:0] r;
        r = a + b;
        return r > SUM_SAT ? SUM_SAT : r[47:0];
    endfunction

    function automatic t_out schedule(t_in e);
        t_out r;
        int n, s, v, pick;
        logic placed, found;
        logic [31:0] turn, resp, wt;
        r = '0;
        n = (ncfg == 0) ? 1 : (ncfg > CORES ? CORES : ncfg);
        if (e.kind == KIND_ARRIVE) begin
            s = -1;
            for (int i = 0; i < SLOTS; i++) if (!jv[i] && s < 0) s = i;
            if (s >= 0) begin
                placed = 0;
                if (pol == POL_PSJF)
                    for (int c = 0; c < CORES; c++) if (cbusy[c]) charge(cslot[c], e.now);
                jv[s] = 1; jid[s] = e.job_id; jarr[s] = e.now; jqt[s] = e.now;
                jurg[s] = e.job_priority; jrem[s] = e.run_length; jlen[s] = e.run_length;
                jseen[s] = 0; jfr[s] = 0; jls[s] = e.now;
                for (int c = 0; c < n; c++)
                    if (!cbusy[c] && !placed) begin
                        run_on(c, s, e.now);
                        r.assigned = 1; r.target_core = 3'(c); placed = 1;
                    end
                if (!placed && (pol == POL_PSJF || pol == POL_PPRI)) begin
                    v = 0;
                    for (int c = 1; c < n; c++) if (bool_ahead(cslot[v], cslot[c])) v = c;
                    if (bool_ahead(s, cslot[v])) begin
                        run_on(v, s, e.now);
                        r.assigned = 1; r.target_core = 3'(v);
                    end
                end
            end
        end else if ((e.kind == KIND_FINISH || e.kind == KIND_EXPIRE) && cbusy[e.core_index]) begin
            s = cslot[e.core_index];
            cbusy[e.core_index] = 0;
            if (e.kind == KIND_FINISH) begin
                turn = e.now - jarr[s];
                resp = jfr[s] - jarr[s];
                wt = (turn >= jlen[s]) ? turn - jlen[s] : 0;
                tsum = sat(tsum, turn);
                wsum = sat(wsum, wt);
                rsum = sat(rsum, resp);
                if (ndone != 16'hFFFF) ndone++;
                jv[s] = 0;
            end else begin
                if (pol == POL_PSJF) charge(s, e.now);
                if (pol == POL_RR) jqt[s] = e.now;
            end
            found = 0; pick = 0;
            for (int i = 0; i < SLOTS; i++)
                if (jv[i] && !on_core(i) && (!found || bool_ahead(i, pick))) begin
                    pick = i; found = 1;
                end
            if (e.core_index < n && found) begin
                run_on(e.core_index, pick, e.now);
                r.assigned = 1; r.core_job = jid[pick];
            end
        end
        r.wait_sum = wsum; r.turnaround_sum = tsum; r.response_sum = rsum;
        r.finished_count = ndone;
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out w;
        if (!i_rst_n) begin
            pol = POL_FCFS; ncfg = 1;
            for (int i = 0; i < SLOTS; i++) begin
                jv[i] = 0; jseen[i] = 0; jid[i] = 0; jarr[i] = 0; jqt[i] = 0;
                jurg[i] = 0; jrem[i] = 0; jlen[i] = 0; jfr[i] = 0; jls[i] = 0;
            end
            for (int c = 0; c < CORES; c++) begin
                cbusy[c] = 0; cslot[c] = 0;
            end
            wsum = 0; tsum = 0; rsum = 0; ndone = 0;
            sched_q.delete();
        end else begin
            if (i_done) begin
                if (sched_q.size() == 0) report("unexpected transfer", 0, 0);
                else begin
                    w = sched_q.pop_front();
                    if (i_out.assigned != w.assigned) report("assigned", i_out.assigned, w.assigned);
                    if (i_out.target_core != w.target_core)
                        report("target_core", i_out.target_core, w.target_core);
                    if (i_out.core_job != w.core_job) report("core_job", i_out.core_job, w.core_job);
                    if (i_out.wait_sum != w.wait_sum) report("wait_sum", i_out.wait_sum, w.wait_sum);
                    if (i_out.turnaround_sum != w.turnaround_sum)
                        report("turnaround_sum", i_out.turnaround_sum, w.turnaround_sum);
                    if (i_out.response_sum != w.response_sum)
                        report("response_sum", i_out.response_sum, w.response_sum);
                    if (i_out.finished_count != w.finished_count)
                        report("finished_count", i_out.finished_count, w.finished_count);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_POLICY) pol = i_cfg_data[2:0];
                else ncfg = i_cfg_data;
            end
            if (i_start && !i_busy) sched_q.push_back(schedule(i_in));
        end
        o_pending <= sched_q.size();
    end
endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mjd_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic       i_clk, i_rst_n, i_cfg_we, i_start;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    t_in        i_in;
    logic       o_busy, o_done;
    t_out       o_out;
    int         errors, pending, quiet;
    // running event timestamp
    logic [31:0] clock_now;

    multicore_job_dispatcher dut (.*);

    mjd_tb_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_start(i_start), .i_busy(o_busy), .i_in(i_in),
        .i_done(o_done), .i_out(o_out), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || !i_rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > QUIET_LIMIT) begin
            $display("[multicore_job_dispatcher] ERROR");
            $finish;
        end
    end

    // one transfer: hold start until accepted, then drop it
    task automatic send(logic [1:0] k, logic [15:0] id, logic [31:0] t,
                        logic [15:0] len, logic [7:0] pri, logic [2:0] core);
        i_in.kind = k; i_in.job_id = id; i_in.now = t; i_in.run_length = len;
        i_in.job_priority = pri; i_in.core_index = core;
        i_start = 1;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
        i_start = 0;
    endtask

    task automatic gap();
        repeat ($urandom_range(0, 7)) @(negedge i_clk);
    endtask

    // drain, let trailing work settle, then write a register
    task automatic drain_and_cfg(logic idx, logic [3:0] val);
        while (pending != 0 || o_busy) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
        i_cfg_idx = idx; i_cfg_data = val; i_cfg_we = 1;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic random_event(int mode);
        logic [1:0] k;
        int r;
        clock_now += $urandom_range(0, 40);
        r = $urandom_range(0, 99);
        if (mode == 1) begin
            // wide-field noise
            k = 2'($urandom_range(0, 3));
            send(k, 16'($urandom), $urandom, 16'($urandom), 8'($urandom), 3'($urandom));
            return;
        end
        k = (r < 45) ? KIND_ARRIVE : (r < 80 ? KIND_FINISH : KIND_EXPIRE);
        send(k, 16'($urandom), clock_now, 16'($urandom_range(1, 300)),
             8'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
    endtask

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = REG_POLICY; i_cfg_data = '0;
        i_start = 0; i_in = '0; clock_now = 100; quiet = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes and corner cases under the reset settings
        send(KIND_FINISH, 16'd0, 32'd5, 16'd1, 8'd0, 3'd0);   // finish on an idle core
        send(KIND_ARRIVE, 16'hFFFF, 32'hFFFF_FFF0, 16'hFFFF, 8'hFF, 3'd7);
        send(KIND_ARRIVE, 16'h0000, 32'h0, 16'h0, 8'h00, 3'd0); // zero run length
        send(KIND_EXPIRE, 16'd1, 32'h10, 16'd1, 8'd0, 3'd0);
        send(KIND_FINISH, 16'd2, 32'hFFFF_FFFF, 16'd1, 8'd0, 3'd0);
        send(KIND_RSVD, 16'hAAAA, 32'h5555_5555, 16'h5555, 8'hAA, 3'd5); // unknown kind
        send(KIND_FINISH, 16'd3, 32'h0, 16'd1, 8'd0, 3'd7);    // idle/out of active
        send(KIND_FINISH, 16'd3, 32'h20, 16'd1, 8'd0, 3'd0);
        drain_and_cfg(REG_ACTIVE, 4'd15);              // above core count
        for (int i = 0; i < 10; i++)
            send(KIND_ARRIVE, 16'(i), 32'(50 + i), 16'(10 + i), 8'(9 - i), 3'd0);
        send(KIND_FINISH, 16'd0, 32'd200, 16'd1, 8'd0, 3'd7);
        send(KIND_EXPIRE, 16'd0, 32'd210, 16'd1, 8'd0, 3'd3);
        drain_and_cfg(REG_ACTIVE, 4'd0);               // zero acts as one
        send(KIND_FINISH, 16'd0, 32'd300, 16'd1, 8'd0, 3'd5);  // busy core beyond active
        send(KIND_FINISH, 16'd0, 32'd310, 16'd1, 8'd0, 3'd0);
        // fill the table to force drops
        for (int i = 0; i < 70; i++)
            send(KIND_ARRIVE, 16'(100 + i), 32'(400 + i), 16'd5, 8'(i), 3'd0);
        for (int i = 0; i < 8; i++) send(KIND_FINISH, 16'd0, 32'(500 + i), 16'd1, 8'd0, 3'(i));
        clock_now = 600;

        // phases over every policy, including the unknown codes
        for (int ph = 0; ph < 10; ph++) begin
            drain_and_cfg(REG_POLICY, (ph < 8) ? 4'(ph) : 4'($urandom_range(0, 5)));
            drain_and_cfg(REG_ACTIVE, (ph == 0) ? 4'd1 :
                                      (ph == 1 ? 4'd8 : 4'($urandom_range(1, 9))));
            for (int i = 0; i < 38; i++) begin
                if (i == 19) while (pending != 0 || o_busy) @(negedge i_clk);
                if ($urandom_range(0, 3) != 0) gap();
                random_event(($urandom_range(0, 19) == 0) ? 1 : 0);
            end
            // finish the running job on every core so each phase starts lighter
            for (int c = 0; c < 8; c++) send(KIND_FINISH, 16'd0, clock_now, 16'd1, 8'd0, 3'(c));
        end

        while (pending != 0 || o_busy) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[multicore_job_dispatcher] OK");
        end else begin
            $display("[multicore_job_dispatcher] ERROR");
        end
        $finish;
    end
endmodule
